// File: sv/srt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package srt_pkg;
   localparam int DEFAULT_TABLE_DEPTH = 64;
   localparam int DEFAULT_ID_BYTES = 8;
   localparam int DATE_W = 23;
   localparam int STATUS_W = 3;

   localparam logic [2:0] CMD_INSERT = 3'd0;
   localparam logic [2:0] CMD_DELETE = 3'd1;
   localparam logic [2:0] CMD_UPDATE = 3'd2;
   localparam logic [2:0] CMD_RANGE  = 3'd3;
   localparam logic [2:0] CMD_LIST   = 3'd4;

   localparam logic [2:0] RC_OK        = 3'd0;
   localparam logic [2:0] RC_INVALID   = 3'd1;
   localparam logic [2:0] RC_DUPLICATE = 3'd2;
   localparam logic [2:0] RC_NOT_FOUND = 3'd3;
   localparam logic [2:0] RC_FULL      = 3'd4;
   localparam logic [2:0] RC_BAD_RANGE = 3'd5;

   localparam logic [2:0] STATUS_MAX = 3'd4;

   // one record as held by a cell
   typedef struct packed {
      logic [63:0] id;
      logic [DATE_W-1:0] date;
      logic [STATUS_W-1:0] status;
   } rec_type;

   // broadcast control from the sequencer to every cell
   typedef struct packed {
      logic shift_up;     // cells above pos take their lower neighbour
      logic shift_down;   // cells at or above pos take their upper neighbour
      logic insert;       // cell at pos takes the new record
      logic out_shift;    // read chain moves one place toward cell 0
      logic load_out;     // read chain loads from the table
   } cell_ctl_type;

   // year / 100 by reciprocal multiplication, exact for any 14-bit year;
   // divisible by 400 when divisible by 100 with a quotient divisible by 4
   function automatic logic date_ok(input logic [13:0] y, input logic [6:0] m,
                                    input logic [6:0] d);
      logic [26:0] prod;
      logic [7:0] q100;
      logic [13:0] rem100;
      logic [4:0] lim;
      logic leap;
      begin
         prod = 27'(y) * 27'd5243;
         q100 = prod[26:19];
         rem100 = y - 14'(q100) * 14'd100;
         leap = ((y[1:0] == 2'b00) && (rem100 != 14'd0)) ||
                ((rem100 == 14'd0) && (q100[1:0] == 2'b00));
         unique case (m)
            7'd4, 7'd6, 7'd9, 7'd11: lim = 5'd30;
            7'd2: lim = leap ? 5'd29 : 5'd28;
            default: lim = 5'd31;
         endcase
         date_ok = (y <= 14'd9999) && (m >= 7'd1) && (m <= 7'd12) && (d >= 7'd1) &&
                   (d <= {2'b00, lim});
      end
   endfunction

   function automatic logic [DATE_W-1:0] pack_date(input logic [13:0] y,
                                                   input logic [6:0] m, input logic [6:0] d);
      pack_date = {y, m[3:0], d[4:0]};
   endfunction
endpackage
`default_nettype wire

// File: sv/sorted_record_table.sv
`timescale 1ns / 1ps
`default_nettype none
// Sorted record table: up to TABLE_DEPTH records (id, date, status) held in a
// row of cells in ascending (date, id) order. Insert and delete shift the row
// by one place; the lookup of an id or of an insert position is a compare
// across all cells. One command is served at a time; an update deletes the
// record and then places it again. Range and list copy the table into a read
// chain that moves toward cell 0 one record per cycle, pausing while a matching
// record waits on a full result register; one matching record is held back so
// the final one can carry tlast. A result register parts the output and holds
// its word while it waits on rsp_tready.
module sorted_record_table #(
   parameter int TABLE_DEPTH = srt_pkg::DEFAULT_TABLE_DEPTH,
   parameter int ID_BYTES = srt_pkg::DEFAULT_ID_BYTES
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic req_tready,
   // command[2:0], record_id[66:3], year[80:67], month[87:81], day[94:88],
   // status_code[97:95], end_year[111:98], end_month[118:112], end_day[125:119],
   // change_date[126], change_status[127]
   input  wire logic [127:0] req_tdata,
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   // out_id[63:0], out_year[77:64], out_month[81:78], out_day[86:82],
   // out_status[89:87], has_record[90], result_code[93:91], zero fill
   output logic [95:0] rsp_tdata,
   output logic rsp_tlast
);
   import srt_pkg::*;
   localparam int PW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_EXEC   = 7'b0000010,
      ST_PLACE  = 7'b0000100,
      ST_STREAM = 7'b0001000,
      ST_RESP   = 7'b0010000,
      ST_WAIT   = 7'b0100000,
      ST_INSERT = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] left_ff, left_in;   // records still in the read chain
   logic pend_valid_ff, pend_valid_in;
   rec_type pend_ff, pend_in;         // matching record held back for tlast
   logic [2:0] code_ff, code_in;
   logic [2:0] cmd_ff;
   logic [63:0] id_ff;
   logic [13:0] y_ff, ey_ff;
   logic [6:0] m_ff, d_ff, em_ff, ed_ff;
   logic [2:0] st_ff;
   logic cd_ff, cs_ff;
   logic [PW-1:0] pos_ff, pos_in;
   rec_type new_ff, new_in;
   logic ovalid_ff, ovalid_in;
   logic [95:0] odata_ff, odata_in;
   logic olast_ff, olast_in;

   rec_type recs [TABLE_DEPTH];
   rec_type outs [TABLE_DEPTH];
   cell_ctl_type ctl;
   logic [TABLE_DEPTH-1:0] hit, ahead;

   logic [63:0] raw_id, norm;
   logic zero_seen;

   // id normal form: keep top ID_BYTES bytes, clear all after the first zero
   always_comb begin
      raw_id = req_tdata[66:3];
      norm = '0;
      zero_seen = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (i >= ID_BYTES || raw_id[56-8*i +: 8] == 8'd0) begin
            zero_seen = 1'b1;
         end
         if (!zero_seen) begin
            norm[56-8*i +: 8] = raw_id[56-8*i +: 8];
         end
      end
   end

   genvar g;
   generate
      for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
         rec_type lower_r, upper_r, upper_o;
         logic [PW-1:0] gi;
         assign gi = PW'(g);
         if (g == 0) begin : g_lo
            assign lower_r = recs[0];
         end else begin : g_lo
            assign lower_r = recs[g-1];
         end
         if (g == TABLE_DEPTH - 1) begin : g_hi
            assign upper_r = recs[g];
            assign upper_o = outs[g];
         end else begin : g_hi
            assign upper_r = recs[g+1];
            assign upper_o = outs[g+1];
         end
         assign hit[g] = (CW'(g) < count_ff) && (recs[g].id == id_ff);
         assign ahead[g] = (CW'(g) < count_ff) && ((recs[g].date < new_ff.date) ||
            ((recs[g].date == new_ff.date) && (recs[g].id < new_ff.id)));
         srt_cell u_cell (
            .clock(clock), .ctl(ctl), .at_or_above(gi >= pos_ff), .at_pos(gi == pos_ff),
            .new_rec(new_ff), .lower_rec(lower_r), .upper_rec(upper_r),
            .upper_out(upper_o), .rec(recs[g]), .out_rec(outs[g])
         );
      end
   endgenerate

   // the table is sorted, so the cells ahead of a new record form a prefix
   // and its place is the first cell that is not ahead
   logic found;
   logic [PW-1:0] hit_pos;
   logic [PW-1:0] place_pos;
   always_comb begin
      found = |hit;
      hit_pos = '0;
      place_pos = PW'(TABLE_DEPTH - 1);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (hit[i]) hit_pos = PW'(i);
      end
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (!ahead[i]) place_pos = PW'(i);
      end
   end

   logic sd_ok, ed_ok_w;
   logic [DATE_W-1:0] lo_d, hi_d;
   logic in_range;
   assign sd_ok = date_ok(y_ff, m_ff, d_ff);
   assign ed_ok_w = date_ok(ey_ff, em_ff, ed_ff);
   assign lo_d = (cmd_ff == CMD_RANGE) ? pack_date(y_ff, m_ff, d_ff) : '0;
   assign hi_d = (cmd_ff == CMD_RANGE) ? pack_date(ey_ff, em_ff, ed_ff) : '1;
   assign in_range = (outs[0].date >= lo_d) && (outs[0].date <= hi_d);

   logic out_free;
   assign out_free = !ovalid_ff || rsp_tready;

   function automatic logic [95:0] status_word(input logic [2:0] code);
      status_word = '0;
      status_word[93:91] = code;
   endfunction

   function automatic logic [95:0] rec_word(input rec_type r);
      rec_word = '0;
      rec_word[63:0] = r.id;
      rec_word[77:64] = r.date[22:9];
      rec_word[81:78] = r.date[8:5];
      rec_word[86:82] = r.date[4:0];
      rec_word[89:87] = r.status;
      rec_word[90] = 1'b1;
   endfunction

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      left_in = left_ff;
      pend_valid_in = pend_valid_ff;
      pend_in = pend_ff;
      code_in = code_ff;
      pos_in = pos_ff;
      new_in = new_ff;
      ctl = '0;
      ovalid_in = ovalid_ff && !rsp_tready;
      odata_in = odata_ff;
      olast_in = olast_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            priority if (cmd_ff == CMD_INSERT) begin
               new_in = '{id: id_ff, date: pack_date(y_ff, m_ff, d_ff), status: st_ff};
               priority if (id_ff == 64'd0 || !sd_ok || st_ff > STATUS_MAX) begin
                  code_in = RC_INVALID;
                  state_in = ST_RESP;
               end else if (found) begin
                  code_in = RC_DUPLICATE;
                  state_in = ST_RESP;
               end else if (count_ff >= CW'(TABLE_DEPTH)) begin
                  code_in = RC_FULL;
                  state_in = ST_RESP;
               end else begin
                  code_in = RC_OK;
                  state_in = ST_PLACE;
               end
            end else if (cmd_ff == CMD_DELETE) begin
               if (found) begin
                  pos_in = hit_pos;
                  code_in = RC_OK;
                  state_in = ST_WAIT;
               end else begin
                  code_in = RC_NOT_FOUND;
                  state_in = ST_RESP;
               end
            end else if (cmd_ff == CMD_UPDATE) begin
               priority if (!cd_ff && !cs_ff) begin
                  code_in = RC_INVALID;
                  state_in = ST_RESP;
               end else if (!found) begin
                  code_in = RC_NOT_FOUND;
                  state_in = ST_RESP;
               end else begin
                  new_in = recs[hit_pos];
                  if (cd_ff && sd_ok) new_in.date = pack_date(y_ff, m_ff, d_ff);
                  if (cs_ff && st_ff <= STATUS_MAX) new_in.status = st_ff;
                  pos_in = hit_pos;
                  code_in = RC_OK;
                  state_in = ST_WAIT;
               end
            end else if (cmd_ff == CMD_RANGE || cmd_ff == CMD_LIST) begin
               if (cmd_ff == CMD_RANGE && (!sd_ok || !ed_ok_w)) begin
                  code_in = RC_BAD_RANGE;
                  state_in = ST_RESP;
               end else begin
                  ctl.load_out = 1'b1;
                  left_in = count_ff;
                  pend_valid_in = 1'b0;
                  state_in = ST_STREAM;
               end
            end else begin
               code_in = RC_INVALID;
               state_in = ST_RESP;
            end
         end
         ST_WAIT: begin
            // remove the record at pos; an update then re-places it
            ctl.shift_down = 1'b1;
            count_in = count_ff - CW'(1);
            state_in = (cmd_ff == CMD_UPDATE) ? ST_PLACE : ST_RESP;
         end
         ST_PLACE: begin
            pos_in = place_pos;
            state_in = ST_INSERT;
         end
         ST_INSERT: begin
            ctl.shift_up = 1'b1;
            ctl.insert = 1'b1;
            count_in = count_ff + CW'(1);
            state_in = ST_RESP;
         end
         ST_STREAM: begin
            if (left_ff == '0) begin
               if (out_free) begin
                  ovalid_in = 1'b1;
                  olast_in = 1'b1;
                  odata_in = pend_valid_ff ? rec_word(pend_ff) : status_word(RC_OK);
                  pend_valid_in = 1'b0;
                  state_in = ST_IDLE;
               end
            end else if (!(in_range && pend_valid_ff) || out_free) begin
               ctl.out_shift = 1'b1;
               left_in = left_ff - CW'(1);
               if (in_range) begin
                  pend_in = outs[0];
                  pend_valid_in = 1'b1;
                  if (pend_valid_ff) begin
                     ovalid_in = 1'b1;
                     olast_in = 1'b0;
                     odata_in = rec_word(pend_ff);
                  end
               end
            end
         end
         ST_RESP: begin
            if (out_free) begin
               ovalid_in = 1'b1;
               olast_in = 1'b1;
               odata_in = status_word(code_ff);
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         ovalid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovalid_ff <= ovalid_in;
         pend_valid_ff <= pend_valid_in;
      end
      left_ff <= left_in;
      pend_ff <= pend_in;
      code_ff <= code_in;
      pos_ff <= pos_in;
      new_ff <= new_in;
      odata_ff <= odata_in;
      olast_ff <= olast_in;
      if (state_ff == ST_IDLE && req_tvalid) begin
         cmd_ff <= req_tdata[2:0];
         id_ff <= norm;
         y_ff <= req_tdata[80:67];
         m_ff <= req_tdata[87:81];
         d_ff <= req_tdata[94:88];
         st_ff <= req_tdata[97:95];
         ey_ff <= req_tdata[111:98];
         em_ff <= req_tdata[118:112];
         ed_ff <= req_tdata[125:119];
         cd_ff <= req_tdata[126];
         cs_ff <= req_tdata[127];
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata = odata_ff;
   assign rsp_tlast = olast_ff;
endmodule
`default_nettype wire

// File: sv/srt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module srt_cell (
   input  wire logic clock,
   input  wire srt_pkg::cell_ctl_type ctl,
   input  wire logic at_or_above,
   input  wire logic at_pos,
   input  wire srt_pkg::rec_type new_rec,
   input  wire srt_pkg::rec_type lower_rec,
   input  wire srt_pkg::rec_type upper_rec,
   input  wire srt_pkg::rec_type upper_out,
   output srt_pkg::rec_type rec,
   output srt_pkg::rec_type out_rec
);
   import srt_pkg::*;
   rec_type rec_ff, rec_in, out_ff, out_in;

   always_comb begin
      rec_in = rec_ff;
      if (ctl.insert && at_pos) begin
         rec_in = new_rec;
      end else if (ctl.shift_up && at_or_above && !at_pos) begin
         rec_in = lower_rec;
      end else if (ctl.shift_down && at_or_above) begin
         rec_in = upper_rec;
      end
      out_in = out_ff;
      if (ctl.load_out) begin
         out_in = rec_ff;
      end else if (ctl.out_shift) begin
         out_in = upper_out;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
      out_ff <= out_in;
   end

   assign rec = rec_ff;
   assign out_rec = out_ff;
endmodule
`default_nettype wire

// File: bench/srt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module srt_checker (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [127:0] req_tdata,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [95:0]  rsp_tdata,
   input  wire logic         rsp_tlast,
   output int                fail_count,
   output int                pending_count
);
   import srt_pkg::*;

   localparam int DEPTH = DEFAULT_TABLE_DEPTH;

   typedef struct packed {
      logic [95:0] data;
      logic        tlast;
   } rsp_word;

   logic [63:0]       tab_id [DEPTH];
   logic [DATE_W-1:0] tab_date [DEPTH];
   logic [2:0]        tab_status [DEPTH];
   int                tab_count;
   rsp_word           expected_rsp [$];

   function automatic logic [63:0] clean_id(input logic [63:0] raw);
      logic [63:0] r;
      begin
         r = '0;
         for (int i = 0; i < 8; i++) begin
            if (raw[63-8*i -: 8] == 8'd0) break;
            r[63-8*i -: 8] = raw[63-8*i -: 8];
         end
         return r;
      end
   endfunction

   function automatic bit valid_date(input int y, input int m, input int d);
      int lim;
      bit leap;
      begin
         leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
         lim = 31;
         if (m == 4 || m == 6 || m == 9 || m == 11) lim = 30;
         else if (m == 2) lim = leap ? 29 : 28;
         return y <= 9999 && m >= 1 && m <= 12 && d >= 1 && d <= lim;
      end
   endfunction

   function automatic int locate_id(input logic [63:0] id);
      begin
         for (int i = 0; i < tab_count; i++)
            if (tab_id[i] == id) return i;
         return -1;
      end
   endfunction

   task automatic drop_slot(input int p);
      begin
         for (int i = p; i + 1 < tab_count; i++) begin
            tab_id[i] = tab_id[i+1];
            tab_date[i] = tab_date[i+1];
            tab_status[i] = tab_status[i+1];
         end
         tab_count--;
      end
   endtask

   task automatic place_sorted(input logic [63:0] id, input logic [DATE_W-1:0] dt,
                               input logic [2:0] st);
      int p;
      begin
         p = 0;
         while (p < tab_count && (tab_date[p] < dt || (tab_date[p] == dt && tab_id[p] < id)))
            p++;
         for (int i = tab_count; i > p; i--) begin
            tab_id[i] = tab_id[i-1];
            tab_date[i] = tab_date[i-1];
            tab_status[i] = tab_status[i-1];
         end
         tab_id[p] = id;
         tab_date[p] = dt;
         tab_status[p] = st;
         tab_count++;
      end
   endtask

   task automatic push_code(input logic [2:0] code);
      rsp_word w;
      begin
         w.data = '0;
         w.data[93:91] = code;
         w.tlast = 1'b1;
         expected_rsp.push_back(w);
      end
   endtask

   task automatic apply_command(input logic [127:0] t);
      logic [2:0] cmd, st;
      logic [63:0] id;
      int y, m, d, ey, em, ed, s, n;
      logic [DATE_W-1:0] dt, lo, hi;
      rsp_word w;
      begin
         cmd = t[2:0];
         id = clean_id(t[66:3]);
         y = int'(t[80:67]); m = int'(t[87:81]); d = int'(t[94:88]); st = t[97:95];
         ey = int'(t[111:98]); em = int'(t[118:112]); ed = int'(t[125:119]);
         dt = {t[80:67], t[84:81], t[92:88]};
         case (cmd)
            CMD_INSERT: begin
               if (id == 0 || !valid_date(y, m, d) || st > STATUS_MAX) push_code(RC_INVALID);
               else if (locate_id(id) >= 0) push_code(RC_DUPLICATE);
               else if (tab_count >= DEPTH) push_code(RC_FULL);
               else begin
                  place_sorted(id, dt, st);
                  push_code(RC_OK);
               end
            end
            CMD_DELETE: begin
               s = locate_id(id);
               if (s < 0) push_code(RC_NOT_FOUND);
               else begin
                  drop_slot(s);
                  push_code(RC_OK);
               end
            end
            CMD_UPDATE: begin
               s = locate_id(id);
               if (!t[126] && !t[127]) push_code(RC_INVALID);
               else if (s < 0) push_code(RC_NOT_FOUND);
               else begin
                  lo = tab_date[s];
                  cmd = tab_status[s];
                  if (t[126] && valid_date(y, m, d)) lo = dt;
                  if (t[127] && st <= STATUS_MAX) cmd = st;
                  drop_slot(s);
                  place_sorted(id, lo, cmd);
                  push_code(RC_OK);
               end
            end
            CMD_RANGE, CMD_LIST: begin
               lo = '0;
               hi = '1;
               if (cmd == CMD_RANGE && (!valid_date(y, m, d) || !valid_date(ey, em, ed))) begin
                  push_code(RC_BAD_RANGE);
                  return;
               end
               if (cmd == CMD_RANGE) begin
                  lo = dt;
                  hi = {t[111:98], t[115:112], t[123:119]};
               end
               n = 0;
               for (int i = 0; i < tab_count; i++) begin
                  if (tab_date[i] >= lo && tab_date[i] <= hi) begin
                     w.data = '0;
                     w.data[63:0] = tab_id[i];
                     w.data[77:64] = tab_date[i][22:9];
                     w.data[81:78] = tab_date[i][8:5];
                     w.data[86:82] = tab_date[i][4:0];
                     w.data[89:87] = tab_status[i];
                     w.data[90] = 1'b1;
                     w.data[93:91] = RC_OK;
                     w.tlast = 1'b0;
                     expected_rsp.push_back(w);
                     n++;
                  end
               end
               if (n == 0) push_code(RC_OK);
               else expected_rsp[$].tlast = 1'b1;
            end
            default: push_code(RC_INVALID);
         endcase
      end
   endtask

   always @(posedge clock) begin
      rsp_word want;
      if (reset) begin
         tab_count = 0;
         fail_count = 0;
         expected_rsp.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsp.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result %h last %b", $time, rsp_tdata, rsp_tlast);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_tdata[63:0] !== want.data[63:0] || rsp_tdata[77:64] !== want.data[77:64]
                   || rsp_tdata[81:78] !== want.data[81:78]
                   || rsp_tdata[86:82] !== want.data[86:82]
                   || rsp_tdata[89:87] !== want.data[89:87] || rsp_tdata[90] !== want.data[90]
                   || rsp_tdata[93:91] !== want.data[93:91] || rsp_tlast !== want.tlast) begin
                  fail_count++;
                  $display("%0t: mismatch expected %h last %b, actual %h last %b", $time,
                           want.data, want.tlast, rsp_tdata, rsp_tlast);
               end
            end
         end
         if (req_tvalid && req_tready) apply_command(req_tdata);
      end
      pending_count = expected_rsp.size();
   end
endmodule
`default_nettype wire

// File: bench/tb_sorted_record_table.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_sorted_record_table;
   import srt_pkg::*;

   logic         clock, reset;
   logic         req_tvalid, req_tready;
   logic [127:0] req_tdata;
   logic         rsp_tvalid, rsp_tready, rsp_tlast;
   logic [95:0]  rsp_tdata;
   int           fail_count, pending_count;
   int           cycle_count = 0;
   bit           calm;
   logic [63:0]  id_pool [16];

   sorted_record_table u_top (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast
   );

   srt_checker u_checker (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast, .fail_count, .pending_count
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3000000) begin
         $display("FAILURE");
         $finish;
      end
   end

   // receiver stalls in bursts
   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   end

   // tvalid stays high between back-to-back transactions and drops only for idling
   task automatic send(input logic [2:0] cmd, input logic [63:0] id, input int y, input int m,
                       input int d, input logic [2:0] st, input int ey, input int em,
                       input int ed, input bit cd, input bit cs);
      begin
         if (!calm && $urandom_range(0, 4) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clock);
         end
         req_tdata <= {cs, cd, ed[6:0], em[6:0], ey[13:0], st, d[6:0], m[6:0], y[13:0], id, cmd};
         req_tvalid <= 1'b1;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         @(negedge clock);
      end
   endtask

   task automatic rand_date(output int y, output int m, output int d, input bit good);
      begin
         if (good || $urandom_range(0, 3) != 0) begin
            y = $urandom_range(0, 3) == 0 ? $urandom_range(0, 9999) : $urandom_range(2000, 2003);
            m = $urandom_range(1, 12);
            d = $urandom_range(1, 28);
            if ($urandom_range(0, 3) == 0) d = $urandom_range(29, 31);
         end else begin
            y = $urandom_range(0, 16383);
            m = $urandom_range(0, 127);
            d = $urandom_range(0, 127);
         end
      end
   endtask

   initial begin
      int y, m, d, ey, em, ed, pick;
      logic [63:0] id;
      logic [2:0] cmd;
      reset = 1'b1;
      calm = 1'b0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      for (int i = 0; i < 16; i++) id_pool[i] = {$urandom(), $urandom()};
      id_pool[0] = 64'h4100_0000_0000_0000;
      id_pool[1] = 64'h4100_4200_0000_0000;   // byte after a zero is dropped
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part
      send(CMD_LIST, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send(CMD_INSERT, 0, 2000, 1, 1, 0, 0, 0, 0, 0, 0);
      send(CMD_INSERT, id_pool[0], 2000, 2, 29, 0, 0, 0, 0, 0, 0);
      send(CMD_INSERT, id_pool[2], 1900, 2, 29, 1, 0, 0, 0, 0, 0);
      send(CMD_INSERT, id_pool[2], 2024, 2, 30, 1, 0, 0, 0, 0, 0);
      send(CMD_INSERT, id_pool[2], 2024, 13, 1, 1, 0, 0, 0, 0, 0);
      send(CMD_INSERT, id_pool[2], 10000, 1, 1, 1, 0, 0, 0, 0, 0);
      send(CMD_INSERT, id_pool[2], 2024, 4, 31, 1, 0, 0, 0, 0, 0);
      send(CMD_INSERT, id_pool[2], 9999, 12, 31, 5, 0, 0, 0, 0, 0);
      send(CMD_INSERT, '1, 9999, 12, 31, 4, 0, 0, 0, 0, 0);
      send(CMD_INSERT, id_pool[3], 0, 1, 1, 2, 0, 0, 0, 0, 0);
      send(CMD_INSERT, id_pool[1], 2000, 2, 29, 3, 0, 0, 0, 0, 0);
      send(CMD_INSERT, 64'h4100_9900_0000_0000, 2001, 1, 1, 3, 0, 0, 0, 0, 0);
      send(CMD_DELETE, id_pool[5], 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send(CMD_UPDATE, id_pool[3], 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send(CMD_UPDATE, id_pool[5], 2000, 1, 1, 0, 0, 0, 0, 1, 1);
      send(CMD_UPDATE, id_pool[3], 2000, 2, 30, 7, 0, 0, 0, 1, 1);
      send(CMD_UPDATE, id_pool[3], 2000, 3, 1, 1, 0, 0, 0, 1, 0);
      send(CMD_UPDATE, '1, 0, 0, 0, 4, 0, 0, 0, 0, 1);
      send(CMD_RANGE, 0, 2000, 1, 1, 0, 2000, 13, 1, 0, 0);
      send(CMD_RANGE, 0, 2000, 1, 0, 0, 2000, 12, 1, 0, 0);
      send(CMD_RANGE, 0, 2000, 12, 31, 0, 2000, 1, 1, 0, 0);
      send(CMD_RANGE, 0, 0, 1, 1, 0, 9999, 12, 31, 0, 0);
      send(3'd5, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1);
      send(3'd7, '1, 16383, 127, 127, 7, 16383, 127, 127, 1, 1);
      send(CMD_DELETE, '1, 0, 0, 0, 0, 0, 0, 0, 0, 0);

      // fill the table past full, then random mixed traffic
      for (int i = 0; i < 70; i++) begin
         rand_date(y, m, d, 1);
         send(CMD_INSERT, {$urandom(), $urandom()} | 64'h0100_0000_0000_0000, y, m, d,
              3'($urandom_range(0, 4)), 0, 0, 0, 0, 0);
      end
      send(CMD_LIST, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      for (int i = 0; i < 150; i++) begin
         if (i == 125) calm = 1'b1;
         pick = $urandom_range(0, 99);
         id = ($urandom_range(0, 4) == 0) ? {$urandom(), $urandom()}
                                          : id_pool[$urandom_range(0, 15)];
         if ($urandom_range(0, 30) == 0) id = '0;
         rand_date(y, m, d, 0);
         rand_date(ey, em, ed, 0);
         if (pick < 30) cmd = CMD_INSERT;
         else if (pick < 50) cmd = CMD_DELETE;
         else if (pick < 72) cmd = CMD_UPDATE;
         else if (pick < 88) cmd = CMD_RANGE;
         else if (pick < 96) cmd = CMD_LIST;
         else cmd = 3'($urandom_range(5, 7));
         send(cmd, id, y, m, d, ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                                            : 3'($urandom_range(0, 4)),
              ey, em, ed, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      req_tvalid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
`default_nettype wire
